FILE: rtl/adl32_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 checksum package
// Shared constants, stage payload types and the modular reduction helpers.
// ----------------------------------------------------------------------------
package adl32_pkg;

   localparam int BYTE_W     = 8;
   localparam int DATA_BYTES = 4;
   localparam int DATA_W     = BYTE_W * DATA_BYTES;
   localparam int COUNT_W    = 3;
   localparam int PROD_W     = BYTE_W + COUNT_W;
   localparam int HALF_W     = 16;
   localparam int SEED_W     = 2 * HALF_W;

   localparam logic [HALF_W-1:0] ADLER_MOD = 16'd65521;

   typedef struct packed {
      logic               first;
      logic               no_buffer;
      logic [SEED_W-1:0]  seed;
      logic [COUNT_W-1:0] count;
   } s1_ctrl_type;

   typedef struct packed {
      s1_ctrl_type        ctrl;
      logic [HALF_W-1:0]  byte_sum;
      logic [HALF_W-1:0]  weighted_sum;
   } s2_ctrl_type;

   // Brings a value below twice the modulus into range.
   function automatic logic [HALF_W-1:0] mod_once(input logic [HALF_W:0] v);
      logic [HALF_W:0] d;
      d = v - {1'b0, ADLER_MOD};
      mod_once = (v >= {1'b0, ADLER_MOD}) ? d[HALF_W-1:0] : v[HALF_W-1:0];
   endfunction

   // Brings a value below three times the modulus into range.
   function automatic logic [HALF_W-1:0] mod_twice(input logic [HALF_W+1:0] v);
      logic [HALF_W+1:0] m1;
      logic [HALF_W+1:0] m2;
      logic [HALF_W+1:0] r;
      m1 = {2'b00, ADLER_MOD};
      m2 = {1'b0, ADLER_MOD, 1'b0};
      if (v >= m2) begin
         r = v - m2;
      end else if (v >= m1) begin
         r = v - m1;
      end else begin
         r = v;
      end
      mod_twice = r[HALF_W-1:0];
   endfunction

endpackage

FILE: rtl/adl32_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 byte lane
// Masks one byte by the request's count and weights it by the number of
// running sums that it still feeds within the request.
// ----------------------------------------------------------------------------
module adl32_lane #(
   parameter int LANE_IDX = 0
) (
   input  logic                               clock,
   input  logic                               load,
   input  logic [adl32_pkg::BYTE_W-1:0]       byte_in,
   input  logic [adl32_pkg::COUNT_W-1:0]      count,
   output logic [adl32_pkg::BYTE_W-1:0]       byte_ff,
   output logic [adl32_pkg::PROD_W-1:0]       prod_ff
);
   import adl32_pkg::*;

   localparam logic [4:0] IDX = 5'(LANE_IDX);

   logic                active;
   logic [COUNT_W-1:0]  weight;
   logic [4:0]          count_ext;
   logic [4:0]          diff;
   logic [BYTE_W-1:0]   byte_in_masked;
   logic [PROD_W-1:0]   prod_in;

   assign count_ext      = {2'b00, count};
   assign active         = count_ext > IDX;
   assign diff           = count_ext - IDX;
   assign weight         = active ? diff[COUNT_W-1:0] : '0;
   assign byte_in_masked = active ? byte_in : '0;
   assign prod_in        = PROD_W'(byte_in_masked) * PROD_W'(weight);

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in_masked;
         prod_ff <= prod_in;
      end
   end

endmodule

FILE: rtl/adl32_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 lane merge
// Adds the lane bytes and the weighted lane bytes into the two per-request
// terms and holds them in the second pipeline stage.
// ----------------------------------------------------------------------------
module adl32_merge #(
   parameter int LANES = 4
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        s1_valid,
   input  adl32_pkg::s1_ctrl_type                      s1_ctrl,
   input  logic [LANES-1:0][adl32_pkg::BYTE_W-1:0]     lane_byte,
   input  logic [LANES-1:0][adl32_pkg::PROD_W-1:0]     lane_prod,
   output logic                                        s1_ready,
   output logic                                        s2_valid,
   output adl32_pkg::s2_ctrl_type                      s2_ctrl,
   input  logic                                        s2_ready
);
   import adl32_pkg::*;

   logic              s2_valid_ff;
   logic              s2_valid_in;
   s2_ctrl_type       s2_ctrl_ff;
   logic [HALF_W-1:0] byte_sum;
   logic [HALF_W-1:0] weighted_sum;
   logic              take;

   always_comb begin
      byte_sum     = '0;
      weighted_sum = '0;
      for (int i = 0; i < LANES; i++) begin
         byte_sum     = byte_sum + HALF_W'(lane_byte[i]);
         weighted_sum = weighted_sum + HALF_W'(lane_prod[i]);
      end
   end

   assign s1_ready    = !s2_valid_ff || s2_ready;
   assign take        = s1_valid && s1_ready;
   assign s2_valid_in = take ? 1'b1 : (s2_ready ? 1'b0 : s2_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s2_ctrl_ff.ctrl         <= s1_ctrl;
         s2_ctrl_ff.byte_sum     <= byte_sum;
         s2_ctrl_ff.weighted_sum <= weighted_sum;
      end
   end

   assign s2_valid = s2_valid_ff;
   assign s2_ctrl  = s2_ctrl_ff;

endmodule

FILE: rtl/adl32_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 accumulator
// Folds the merged request terms into the two running sums and holds the
// checksum in the output register.
// ----------------------------------------------------------------------------
module adl32_accum (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                s2_valid,
   input  adl32_pkg::s2_ctrl_type              s2_ctrl,
   output logic                                s2_ready,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [adl32_pkg::SEED_W-1:0]        rsp_checksum
);
   import adl32_pkg::*;

   logic [HALF_W-1:0]  sum_low_ff;
   logic [HALF_W-1:0]  sum_low_in;
   logic [HALF_W-1:0]  sum_high_ff;
   logic [HALF_W-1:0]  sum_high_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [SEED_W-1:0]  rsp_data_ff;

   logic               fire;
   logic [HALF_W-1:0]  base_low;
   logic [HALF_W-1:0]  base_high;
   logic [HALF_W-1:0]  low0;
   logic [HALF_W-1:0]  high0;
   logic [HALF_W-1:0]  low_new;
   logic [18:0]        prod;
   logic [HALF_W:0]    fold;
   logic [HALF_W-1:0]  cross_term;
   logic [HALF_W+1:0]  high_sum;
   logic [HALF_W-1:0]  high_new;

   assign s2_ready = !rsp_valid_ff || rsp_ready;
   assign fire     = s2_valid && s2_ready;

   always_comb begin
      base_low  = s2_ctrl.ctrl.first ? s2_ctrl.ctrl.seed[HALF_W-1:0] : sum_low_ff;
      base_high = s2_ctrl.ctrl.first ? s2_ctrl.ctrl.seed[SEED_W-1:HALF_W] : sum_high_ff;
      low0      = mod_once({1'b0, base_low});
      high0     = mod_once({1'b0, base_high});
      low_new   = mod_once({1'b0, low0} + {1'b0, s2_ctrl.byte_sum});
      // 2^16 is congruent to 15, so the top bits fold back times fifteen.
      prod      = 19'(low0) * 19'(s2_ctrl.ctrl.count);
      fold      = {1'b0, prod[HALF_W-1:0]}
                + 17'({prod[18:16], 4'b0000}) - 17'(prod[18:16]);
      cross_term = mod_once(fold);
      high_sum  = 18'(high0) + 18'(cross_term) + 18'(s2_ctrl.weighted_sum);
      high_new  = mod_twice(high_sum);

      if (s2_ctrl.ctrl.no_buffer) begin
         sum_low_in  = 16'd1;
         sum_high_in = '0;
      end else if (s2_ctrl.ctrl.count == '0) begin
         sum_low_in  = base_low;
         sum_high_in = base_high;
      end else begin
         sum_low_in  = low_new;
         sum_high_in = high_new;
      end

      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_low_ff   <= 16'd1;
         sum_high_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            sum_low_ff  <= sum_low_in;
            sum_high_ff <= sum_high_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= {sum_high_in, sum_low_in};
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = rsp_data_ff;

`ifndef SYNTHESIS
   a_rsp_matches_sums: assert property (@(posedge clock) disable iff (reset)
      fire |=> (rsp_data_ff == {sum_high_ff, sum_low_ff}))
      else $error("Response checksum differs from the running sums.");

   a_no_buffer_gives_one: assert property (@(posedge clock) disable iff (reset)
      (fire && s2_ctrl.ctrl.no_buffer) |=> (rsp_data_ff == 32'd1))
      else $error("Absent-buffer request did not return one.");

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      (fire && !s2_ctrl.ctrl.no_buffer && (s2_ctrl.ctrl.count != '0))
      |=> ((sum_low_ff < ADLER_MOD) && (sum_high_ff < ADLER_MOD)))
      else $error("Running sums not reduced after absorbing bytes.");
`endif

endmodule

FILE: rtl/adler32_checksum_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Adler-32 checksum unit
// Running Adler-32 checksum over a byte stream, up to four bytes per request,
// with byte lanes side by side, a lane merge and a running-sum accumulator.
//
//   Channel | Direction | Fields
//   req     | in        | first, seed, no_buffer, data_bytes, byte_count
//   rsp     | out       | checksum
//
// One request per cycle is sustained while responses are taken; a checksum passes
// in turn through the lane stage, the merge stage and the output register.
// The running-sum update with its modular folding is combinational ahead of the sum registers.
// Reset sets the sums to the Adler-32 start value 1; no clearing pass.
// Each stage holds while full and its successor is stalled; earlier stages
// keep taking requests until they fill.
// ----------------------------------------------------------------------------
module adler32_checksum_unit #(
   parameter int LANES = 4
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_first,
   input  logic [adl32_pkg::SEED_W-1:0]        req_seed,
   input  logic                                req_no_buffer,
   input  logic [adl32_pkg::DATA_W-1:0]        req_data_bytes,
   input  logic [adl32_pkg::COUNT_W-1:0]       req_byte_count,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [adl32_pkg::SEED_W-1:0]        rsp_checksum
);
   import adl32_pkg::*;

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   s1_ctrl_type                     s1_ctrl_ff;
   logic                            s1_ready;
   logic                            load;
   logic [COUNT_W-1:0]              count_sat;
   logic [LANES-1:0][BYTE_W-1:0]    lane_byte;
   logic [LANES-1:0][PROD_W-1:0]    lane_prod;
   logic                            s2_valid;
   s2_ctrl_type                     s2_ctrl;
   logic                            s2_ready;

   assign count_sat = ({2'b00, req_byte_count} > 5'(LANES)) ? COUNT_W'(LANES)
                                                            : req_byte_count;
   assign req_ready   = !s1_valid_ff || s1_ready;
   assign load        = req_valid && req_ready;
   assign s1_valid_in = load ? 1'b1 : (s1_ready ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_ctrl_ff.first     <= req_first;
         s1_ctrl_ff.no_buffer <= req_no_buffer;
         s1_ctrl_ff.seed      <= req_seed;
         s1_ctrl_ff.count     <= count_sat;
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic [BYTE_W-1:0] lane_in;
      if (i < DATA_BYTES) begin : g_data
         assign lane_in = req_data_bytes[i*BYTE_W +: BYTE_W];
      end else begin : g_zero
         assign lane_in = '0;
      end
      adl32_lane #(
         .LANE_IDX (i)
      ) u_lane (
         .clock   (clock),
         .load    (load),
         .byte_in (lane_in),
         .count   (count_sat),
         .byte_ff (lane_byte[i]),
         .prod_ff (lane_prod[i])
      );
   end

   adl32_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .s1_valid  (s1_valid_ff),
      .s1_ctrl   (s1_ctrl_ff),
      .lane_byte (lane_byte),
      .lane_prod (lane_prod),
      .s1_ready  (s1_ready),
      .s2_valid  (s2_valid),
      .s2_ctrl   (s2_ctrl),
      .s2_ready  (s2_ready)
   );

   adl32_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .s2_valid     (s2_valid),
      .s2_ctrl      (s2_ctrl),
      .s2_ready     (s2_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_checksum (rsp_checksum)
   );

endmodule
